>>> design/sfrp_pkg.sv
package sfrp_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned WIN_LEN   = 5;
   localparam int unsigned HIST_LEN  = WIN_LEN - 1;
   localparam int unsigned FILL_W    = 3;
   localparam int unsigned CSR_IDX_W = 2;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH  = 2'd2;

   // Register reset values
   localparam logic [BYTE_W-1:0] HEADER_RST  = 8'hAA;
   localparam logic [BYTE_W-1:0] COMMAND_RST = 8'h01;
   localparam logic [BYTE_W-1:0] LENGTH_RST  = 8'h01;

   typedef struct packed {
      logic [BYTE_W-1:0] header_byte;
      logic [BYTE_W-1:0] expected_command;
      logic [BYTE_W-1:0] expected_length;
   } sfrp_cfg_type;

   typedef struct packed {
      logic              hit;
      logic [BYTE_W-1:0] play_state;
   } sfrp_result_type;

endpackage

>>> design/sfrp_req_if.sv
interface sfrp_req_if;
   import sfrp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

>>> design/sfrp_rsp_if.sv
interface sfrp_rsp_if;
   import sfrp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] play_state;

   modport source (output valid, output play_state, input ready);
   modport sink (input valid, input play_state, output ready);
endinterface

>>> design/sfrp_window.sv
module sfrp_window (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              rx_byte,
   input  sfrp_pkg::sfrp_cfg_type  cfg,
   output sfrp_pkg::sfrp_result_type result
);
   import sfrp_pkg::*;

   logic [BYTE_W-1:0] hist_ff [HIST_LEN];
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              full;
   logic [BYTE_W-1:0] sum;
   logic              frame_ok;

   // Four bytes held plus the arriving one make a full frame
   assign full = (fill_ff == FILL_W'(HIST_LEN));
   assign sum  = hist_ff[0] + hist_ff[1] + hist_ff[2] + hist_ff[3];

   assign frame_ok = (hist_ff[0] == cfg.header_byte) &&
                     (sum == rx_byte) &&
                     (hist_ff[1] == cfg.expected_command) &&
                     (hist_ff[2] == cfg.expected_length);

   assign result.hit        = accept && full && frame_ok;
   assign result.play_state = hist_ff[3];

   // Advance the fill count: count up, empty on a frame, hold when sliding
   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         if (!full) begin
            fill_in = fill_ff + FILL_W'(1);
         end else if (frame_ok) begin
            fill_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Store the byte at the fill position, slide the window by one byte, or hold on a frame
   always_ff @(posedge clock) begin
      if (accept) begin
         if (!full) begin
            hist_ff[fill_ff[1:0]] <= rx_byte;
         end else if (!frame_ok) begin
            for (int i = 0; i < HIST_LEN - 1; i++) begin
               hist_ff[i] <= hist_ff[i+1];
            end
            hist_ff[HIST_LEN-1] <= rx_byte;
         end
      end
   end

endmodule

>>> design/status_frame_resync_parser.sv
// Output path: a frame's play_state word is registered at the edge that accepts its last
//   byte: into the output register, or into the skid stage if its word is not being taken.
// Throughput: one byte per cycle while req ready is high; the window check is combinational.
//   req ready drops only while both the output register and the skid stage hold words.
// Reset clears the fill count, both output stages and the registers to their
//   defaults; the window bytes are not cleared.
module status_frame_resync_parser (
   input  logic                          clock,
   input  logic                          reset,
   sfrp_req_if.sink                      req_if,
   sfrp_rsp_if.source                    rsp_if,
   input  logic                          csr_we,
   input  logic [sfrp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_wdata
);
   import sfrp_pkg::*;

   sfrp_cfg_type      cfg_ff;
   sfrp_result_type   win_res;
   logic              accept;
   logic              pop;
   logic              out_valid_ff;
   logic [BYTE_W-1:0] out_data_ff;
   logic              skid_valid_ff;
   logic [BYTE_W-1:0] skid_data_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_byte      <= HEADER_RST;
         cfg_ff.expected_command <= COMMAND_RST;
         cfg_ff.expected_length  <= LENGTH_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HEADER:  cfg_ff.header_byte      <= csr_wdata;
            CSR_COMMAND: cfg_ff.expected_command <= csr_wdata;
            CSR_LENGTH:  cfg_ff.expected_length  <= csr_wdata;
            default:     cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign req_if.ready = !skid_valid_ff;
   assign accept       = req_if.valid && req_if.ready;
   assign pop          = out_valid_ff && rsp_if.ready;

   sfrp_window u_window (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_if.rx_byte),
      .cfg     (cfg_ff),
      .result  (win_res)
   );

   // Output register with skid stage behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_ff <= win_res.hit;
      end else if (win_res.hit) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (!out_valid_ff || pop) begin
         if (win_res.hit) begin
            out_data_ff <= win_res.play_state;
         end
      end else if (win_res.hit) begin
         skid_data_ff <= win_res.play_state;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.play_state = out_data_ff;

   // Skid stage is only ever filled behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a word while output register is empty");

   // A word taken with the skid full is replaced by the skid word
   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      (pop && skid_valid_ff) |=> (out_valid_ff && out_data_ff == $past(skid_data_ff)))
      else $error("skid word not moved into output register");

   // Reset empties both output stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !skid_valid_ff))
      else $error("output stages not empty after reset");

endmodule
